// ----- rtl/core/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and the constant unit-circle table of the tessellator.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int CIRCLE_SEGMENTS = 16;
	localparam int SEG_W = $clog2(CIRCLE_SEGMENTS);
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam logic [63:0] PI_OVER_4_Q30 = 64'd843314857;
	localparam logic [63:0] TRIG_ONE = 64'd1 << 30;

	typedef enum logic [1:0] {
		OP_QUAD   = 2'd0,
		OP_CIRCLE = 2'd1,
		OP_LINE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef logic signed [34:0] wide_t;

	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
	} unit_t;

	typedef unit_t [CIRCLE_SEGMENTS-1:0] unit_tab_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [30:0]        rad;
		logic [30:0]        ta;
		logic [30:0]        tb;
		logic [31:0]        ca;
		logic [31:0]        cb;
		logic signed [31:0] z;
	} item_t;

	typedef struct packed {
		op_t                op;
		wide_t [3:0]        px;
		wide_t [3:0]        py;
		wide_t              cx;
		wide_t              cy;
		logic [30:0]        rad;
		logic [31:0]        ca;
		logic [31:0]        cb;
		logic signed [31:0] z;
	} prim_t;

	typedef struct packed {
		logic signed [31:0] v0x;
		logic signed [31:0] v0y;
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
		logic signed [31:0] z;
		logic [31:0]        c0;
		logic [31:0]        c1;
		logic [31:0]        c2;
		logic               last;
	} tri_t;

	typedef struct packed {
		logic busy;
		logic take;
		logic issue;
		logic last;
	} stat_t;

	function automatic unit_t unit_vec(input int k);
		logic [63:0] kk;
		logic [63:0] oct;
		logic [63:0] rem;
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] c;
		logic [63:0] s;
		unit_t u;
		kk = 64'(k % CIRCLE_SEGMENTS);
		oct = (8 * kk) / CIRCLE_SEGMENTS;
		rem = 8 * kk - oct * CIRCLE_SEGMENTS;
		x = (rem * PI_OVER_4_Q30 + CIRCLE_SEGMENTS / 2) / CIRCLE_SEGMENTS;
		if (x > PI_OVER_4_Q30)
			x = PI_OVER_4_Q30;
		t = oct[0] ? PI_OVER_4_Q30 - x : x;
		x2 = (t * t + (TRIG_ONE >> 1)) >> 30;
		term = t;
		pos = '0;
		neg = '0;
		for (int i = 0; i < 7; i++) begin
			if (i % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
			term = ((term * x2) >> 30) / 64'((2 * i + 2) * (2 * i + 3));
		end
		s = (pos > neg) ? pos - neg : 64'd0;
		term = TRIG_ONE;
		pos = '0;
		neg = '0;
		for (int i = 0; i < 7; i++) begin
			if (i % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
			term = ((term * x2) >> 30) / 64'((2 * i + 1) * (2 * i + 2));
		end
		c = (pos > neg) ? pos - neg : 64'd0;
		if (c > TRIG_ONE)
			c = TRIG_ONE;
		if (s > TRIG_ONE)
			s = TRIG_ONE;
		unique case (oct[2:0])
			3'd0: begin u.ux = 32'(c); u.uy = 32'(s); end
			3'd1: begin u.ux = 32'(s); u.uy = 32'(c); end
			3'd2: begin u.ux = -32'(s); u.uy = 32'(c); end
			3'd3: begin u.ux = -32'(c); u.uy = 32'(s); end
			3'd4: begin u.ux = -32'(c); u.uy = -32'(s); end
			3'd5: begin u.ux = -32'(s); u.uy = -32'(c); end
			3'd6: begin u.ux = 32'(s); u.uy = -32'(c); end
			default: begin u.ux = 32'(c); u.uy = -32'(s); end
		endcase
		return u;
	endfunction

	function automatic unit_tab_t build_unit_tab();
		unit_tab_t tab;
		for (int k = 0; k < CIRCLE_SEGMENTS; k++)
			tab[k] = unit_vec(k);
		return tab;
	endfunction

	localparam unit_tab_t UNIT_TAB = build_unit_tab();

endpackage

// ----- rtl/core/ptt_isqrt.sv -----
// ----------------------------------------------------------------------------
// ptt_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ptt_isqrt
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [62:0] v,
	output logic [31:0] root
);

	logic [62:0] rem_s [SQRT_STEPS];
	logic [62:0] acc_s [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [62:0] BIT = 63'd1 << (2 * (SQRT_STEPS - 1 - i));
		logic [62:0] rem_in;
		logic [62:0] acc_in;
		logic [62:0] trial;
		if (i == 0) begin : g_first
			assign rem_in = v;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign acc_in = acc_s[i-1];
		end
		assign trial = acc_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[i] <= rem_in - trial;
					acc_s[i] <= (acc_in >> 1) + BIT;
				end else begin
					rem_s[i] <= rem_in;
					acc_s[i] <= acc_in >> 1;
				end
			end
		end
	end

	assign root = acc_s[SQRT_STEPS-1][31:0];

endmodule

// ----- rtl/core/ptt_div.sv -----
// ----------------------------------------------------------------------------
// ptt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptt_div
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [62:0] num,
	input  logic [32:0] den,
	output logic [30:0] quo
);

	logic [62:0] rem_s [DIV_STEPS];
	logic [32:0] den_s [DIV_STEPS];
	logic [30:0] quo_s [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - i;
		logic [62:0] rem_in;
		logic [32:0] den_in;
		logic [30:0] quo_in;
		logic [63:0] trial;
		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end
		assign trial = 64'(den_in) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_in;
				if (64'(rem_in) >= trial) begin
					rem_s[i] <= rem_in - trial[62:0];
					quo_s[i] <= quo_in | (31'd1 << SH);
				end else begin
					rem_s[i] <= rem_in;
					quo_s[i] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

// ----- rtl/core/ptt_setup.sv -----
// ----------------------------------------------------------------------------
// ptt_setup
// Front pipeline: quad halves, line direction normalising, length and
// per-end offsets, giving the four corner points of each primitive.
// ----------------------------------------------------------------------------
module ptt_setup
	import ptt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  res_valid,
	output prim_t res
);

	typedef struct packed {
		item_t              item;
		logic               dx_neg;
		logic               dy_pos;
		logic               degen;
		logic signed [32:0] hx;
		logic signed [32:0] hy;
		logic [32:0]        mx;
		logic [32:0]        my;
	} side_t;

	// stage 1: differences, magnitudes, quad halves
	logic signed [33:0] dx, dy;
	logic [31:0]        bxm, bym;
	logic [32:0]        hxs, hys;
	side_t              side_c1;

	assign dx = 34'(in_item.bx) - 34'(in_item.ax);
	assign dy = 34'(in_item.by) - 34'(in_item.ay);
	assign bxm = in_item.bx[31] ? 32'(-in_item.bx) : 32'(in_item.bx);
	assign bym = in_item.by[31] ? 32'(-in_item.by) : 32'(in_item.by);
	assign hxs = {1'b0, bxm} + 33'd1;
	assign hys = {1'b0, bym} + 33'd1;

	always_comb begin
		side_c1.item = in_item;
		side_c1.dx_neg = dx[33];
		side_c1.dy_pos = !dy[33] && (dy != '0);
		side_c1.degen = (dx == '0) && (dy == '0);
		side_c1.hx = in_item.bx[31] ? -$signed({1'b0, hxs[32:1]}) : $signed({1'b0, hxs[32:1]});
		side_c1.hy = in_item.by[31] ? -$signed({1'b0, hys[32:1]}) : $signed({1'b0, hys[32:1]});
		side_c1.mx = dx[33] ? 33'(-dx) : 33'(dx);
		side_c1.my = dy[33] ? 33'(-dy) : 33'(dy);
	end

	side_t side_s1, side_s2, side_s3;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage 2: coarse normalising
	logic [32:0] m2, a2, b2, m2a, a2a, b2a;
	side_t       side_c2;

	always_comb begin
		m2 = (side_s1.mx > side_s1.my) ? side_s1.mx : side_s1.my;
		if (m2[32] || m2[31]) begin
			m2a = m2 >> 1;
			a2a = side_s1.mx >> 1;
			b2a = side_s1.my >> 1;
		end else begin
			m2a = m2;
			a2a = side_s1.mx;
			b2a = side_s1.my;
		end
		a2 = a2a;
		b2 = b2a;
		if (m2a < (33'd1 << 15)) begin
			m2a = m2a << 16;
			a2 = a2 << 16;
			b2 = b2 << 16;
		end
		if (m2a < (33'd1 << 23)) begin
			a2 = a2 << 8;
			b2 = b2 << 8;
		end
		side_c2 = side_s1;
		side_c2.mx = a2;
		side_c2.my = b2;
	end

	// stage 3: fine normalising
	logic [32:0] m3, a3, b3;
	side_t       side_c3;

	always_comb begin
		a3 = side_s2.mx;
		b3 = side_s2.my;
		m3 = (a3 > b3) ? a3 : b3;
		if (m3 < (33'd1 << 27)) begin
			m3 = m3 << 4;
			a3 = a3 << 4;
			b3 = b3 << 4;
		end
		if (m3 < (33'd1 << 29)) begin
			m3 = m3 << 2;
			a3 = a3 << 2;
			b3 = b3 << 2;
		end
		if (m3 < (33'd1 << 30)) begin
			a3 = a3 << 1;
			b3 = b3 << 1;
		end
		side_c3 = side_s2;
		side_c3.mx = a3;
		side_c3.my = b3;
	end

	logic [61:0] sqx_s4, sqy_s4;
	side_t       side_s4, side_s5;
	logic [62:0] sum_s5;
	logic [31:0] root;

	side_t       dla [SQRT_STEPS];
	logic        dla_v [SQRT_STEPS];
	side_t       side_s6, side_s7;
	logic [61:0] pax_s6, pay_s6, pbx_s6, pby_s6;
	logic [31:0] len_s6;
	logic [62:0] nax_s7, nay_s7, nbx_s7, nby_s7;
	logic [32:0] den_s7;
	side_t       dlb [DIV_STEPS];
	logic        dlb_v [DIV_STEPS];
	logic [30:0] qax, qay, qbx, qby;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int i = 0; i < SQRT_STEPS; i++)
				dla_v[i] <= 1'b0;
			for (int i = 0; i < DIV_STEPS; i++)
				dlb_v[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dla_v[0] <= v_s5;
			for (int i = 1; i < SQRT_STEPS; i++)
				dla_v[i] <= dla_v[i-1];
			v_s6 <= dla_v[SQRT_STEPS-1];
			v_s7 <= v_s6;
			dlb_v[0] <= v_s7;
			for (int i = 1; i < DIV_STEPS; i++)
				dlb_v[i] <= dlb_v[i-1];
			v_s8 <= dlb_v[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
			side_s2 <= side_c2;
			side_s3 <= side_c3;
			side_s4 <= side_s3;
			sqx_s4 <= side_s3.mx[30:0] * side_s3.mx[30:0];
			sqy_s4 <= side_s3.my[30:0] * side_s3.my[30:0];
			side_s5 <= side_s4;
			sum_s5 <= 63'(sqx_s4) + 63'(sqy_s4);
			dla[0] <= side_s5;
			for (int i = 1; i < SQRT_STEPS; i++)
				dla[i] <= dla[i-1];
			side_s6 <= dla[SQRT_STEPS-1];
			len_s6 <= root;
			pax_s6 <= dla[SQRT_STEPS-1].my[30:0] * dla[SQRT_STEPS-1].item.ta;
			pay_s6 <= dla[SQRT_STEPS-1].mx[30:0] * dla[SQRT_STEPS-1].item.ta;
			pbx_s6 <= dla[SQRT_STEPS-1].my[30:0] * dla[SQRT_STEPS-1].item.tb;
			pby_s6 <= dla[SQRT_STEPS-1].mx[30:0] * dla[SQRT_STEPS-1].item.tb;
			side_s7 <= side_s6;
			nax_s7 <= 63'(pax_s6) + 63'(len_s6);
			nay_s7 <= 63'(pay_s6) + 63'(len_s6);
			nbx_s7 <= 63'(pbx_s6) + 63'(len_s6);
			nby_s7 <= 63'(pby_s6) + 63'(len_s6);
			den_s7 <= {len_s6, 1'b0};
			dlb[0] <= side_s7;
			for (int i = 1; i < DIV_STEPS; i++)
				dlb[i] <= dlb[i-1];
		end
	end

	ptt_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.v    (sum_s5),
		.root (root)
	);

	ptt_div u_div_ax (.clk(clk), .en(en), .num(nax_s7), .den(den_s7), .quo(qax));
	ptt_div u_div_ay (.clk(clk), .en(en), .num(nay_s7), .den(den_s7), .quo(qay));
	ptt_div u_div_bx (.clk(clk), .en(en), .num(nbx_s7), .den(den_s7), .quo(qbx));
	ptt_div u_div_by (.clk(clk), .en(en), .num(nby_s7), .den(den_s7), .quo(qby));

	// final stage: offsets and corners
	side_t              sf;
	logic [31:0]        hta, htb;
	wide_t              sax, say, sbx, sby;
	wide_t              ax, ay, bx, by, hx, hy;
	prim_t              res_c;
	prim_t              res_s8;

	assign sf = dlb[DIV_STEPS-1];
	assign hta = 32'((33'(sf.item.ta) + 33'd1) >> 1);
	assign htb = 32'((33'(sf.item.tb) + 33'd1) >> 1);

	always_comb begin
		ax = 35'(sf.item.ax);
		ay = 35'(sf.item.ay);
		bx = 35'(sf.item.bx);
		by = 35'(sf.item.by);
		hx = 35'(sf.hx);
		hy = 35'(sf.hy);
		if (sf.degen) begin
			sax = '0;
			say = $signed({3'b000, hta});
			sbx = '0;
			sby = $signed({3'b000, htb});
		end else begin
			sax = sf.dy_pos ? -$signed({4'b0000, qax}) : $signed({4'b0000, qax});
			say = sf.dx_neg ? -$signed({4'b0000, qay}) : $signed({4'b0000, qay});
			sbx = sf.dy_pos ? -$signed({4'b0000, qbx}) : $signed({4'b0000, qbx});
			sby = sf.dx_neg ? -$signed({4'b0000, qby}) : $signed({4'b0000, qby});
		end
		res_c.op = sf.item.op;
		res_c.cx = ax;
		res_c.cy = ay;
		res_c.rad = sf.item.rad;
		res_c.ca = sf.item.ca;
		res_c.cb = sf.item.cb;
		res_c.z = sf.item.z;
		if (sf.item.op == OP_QUAD) begin
			res_c.px[0] = ax + hx; res_c.py[0] = ay + hy;
			res_c.px[1] = ax - hx; res_c.py[1] = ay + hy;
			res_c.px[2] = ax + hx; res_c.py[2] = ay - hy;
			res_c.px[3] = ax - hx; res_c.py[3] = ay - hy;
		end else begin
			res_c.px[0] = ax - sax; res_c.py[0] = ay - say;
			res_c.px[1] = ax + sax; res_c.py[1] = ay + say;
			res_c.px[2] = bx - sbx; res_c.py[2] = by - sby;
			res_c.px[3] = bx + sbx; res_c.py[3] = by + sby;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s8 <= res_c;
	end

	assign res_valid = v_s8;
	assign res = res_s8;

endmodule

// ----- rtl/core/ptt_emit.sv -----
// ----------------------------------------------------------------------------
// ptt_emit
// Triangle sequencer and back pipeline: issues one triangle per cycle while
// not stalled, scales circle rim points, saturates into the output register.
// ----------------------------------------------------------------------------
module ptt_emit
	import ptt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  prim_t in_prim,
	input  logic  out_ready,
	output stat_t stat,
	output logic  out_valid,
	output tri_t  out_tri
);

	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(CIRCLE_SEGMENTS - 1);

	typedef struct packed {
		logic               circle;
		logic [1:0]         neg1;
		logic [1:0]         neg2;
		wide_t [2:0]        vx;
		wide_t [2:0]        vy;
		logic [2:0] [31:0]  col;
		logic signed [31:0] z;
		logic               last;
	} job_t;

	logic              busy_q;
	logic [SEG_W-1:0]  cnt_q;
	prim_t             cur_q;
	logic              ben, issue, last_job, take;
	logic [SEG_W-1:0]  k1;
	unit_t             u1, u2;
	job_t              job_c, job_s0, job_s1, job_s2;
	logic [30:0]       rad_s0, rad_c;
	logic [3:0] [30:0] mag_s0, mag_c;
	logic              v_s0, v_s1, v_s2, out_valid_q;
	tri_t              out_q;

	assign ben = !out_valid_q || out_ready;
	assign issue = busy_q && ben;
	assign last_job = (cur_q.op == OP_CIRCLE) ? (cnt_q == SEG_LAST) : (cnt_q == SEG_W'(1));
	assign take = !busy_q || (issue && last_job);

	assign stat.busy = busy_q;
	assign stat.take = take;
	assign stat.issue = issue;
	assign stat.last = last_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			busy_q <= in_valid && (in_prim.op != OP_NONE);
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + SEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= in_prim;
	end

	assign k1 = (cnt_q == SEG_LAST) ? '0 : cnt_q + SEG_W'(1);
	assign u1 = UNIT_TAB[cnt_q];
	assign u2 = UNIT_TAB[k1];

	function automatic logic [30:0] mag31(input logic signed [31:0] u);
		logic [31:0] m;
		m = u[31] ? 32'(-u) : 32'(u);
		return m[30:0];
	endfunction

	always_comb begin
		job_c.circle = 1'b0;
		job_c.neg1 = {u1.uy[31], u1.ux[31]};
		job_c.neg2 = {u2.uy[31], u2.ux[31]};
		job_c.z = cur_q.z;
		job_c.last = last_job;
		job_c.col = {cur_q.ca, cur_q.ca, cur_q.ca};
		job_c.vx = {cur_q.cx, cur_q.cx, cur_q.cx};
		job_c.vy = {cur_q.cy, cur_q.cy, cur_q.cy};
		rad_c = cur_q.rad;
		mag_c = {mag31(u2.uy), mag31(u2.ux), mag31(u1.uy), mag31(u1.ux)};
		unique case (cur_q.op)
			OP_CIRCLE: begin
				job_c.circle = 1'b1;
			end
			OP_QUAD: begin
				if (cnt_q == '0) begin
					job_c.vx = {cur_q.px[2], cur_q.px[0], cur_q.px[1]};
					job_c.vy = {cur_q.py[2], cur_q.py[0], cur_q.py[1]};
				end else begin
					job_c.vx = {cur_q.px[3], cur_q.px[1], cur_q.px[2]};
					job_c.vy = {cur_q.py[3], cur_q.py[1], cur_q.py[2]};
				end
			end
			OP_LINE: begin
				if (cnt_q == '0) begin
					job_c.vx = {cur_q.px[2], cur_q.px[3], cur_q.px[0]};
					job_c.vy = {cur_q.py[2], cur_q.py[3], cur_q.py[0]};
					job_c.col = {cur_q.cb, cur_q.cb, cur_q.ca};
				end else begin
					job_c.vx = {cur_q.px[3], cur_q.px[1], cur_q.px[0]};
					job_c.vy = {cur_q.py[3], cur_q.py[1], cur_q.py[0]};
					job_c.col = {cur_q.cb, cur_q.ca, cur_q.ca};
				end
			end
			default: begin
				job_c.circle = 1'b0;
			end
		endcase
	end

	// partial products of radius times unit magnitude
	logic [3:0] [46:0] plo_s1;
	logic [3:0] [45:0] phi_s1;
	logic [3:0] [31:0] pm_s2;
	logic [3:0] [61:0] tot;

	always_comb begin
		for (int i = 0; i < 4; i++)
			tot[i] = 62'(plo_s1[i]) + (62'(phi_s1[i]) << 16) + (62'd1 << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ben) begin
			v_s0 <= issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			job_s0 <= job_c;
			rad_s0 <= rad_c;
			mag_s0 <= mag_c;
			job_s1 <= job_s0;
			for (int i = 0; i < 4; i++) begin
				plo_s1[i] <= rad_s0 * mag_s0[i][15:0];
				phi_s1[i] <= rad_s0 * mag_s0[i][30:16];
			end
			job_s2 <= job_s1;
			for (int i = 0; i < 4; i++)
				pm_s2[i] <= tot[i][61:30];
		end
	end

	function automatic logic signed [31:0] sat32(input wide_t v);
		if (v > 35'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -35'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic wide_t rim(input wide_t c, input logic neg, input logic [31:0] p);
		wide_t pw;
		pw = $signed({3'b000, p});
		return neg ? c - pw : c + pw;
	endfunction

	wide_t v1x, v1y, v2x, v2y;

	always_comb begin
		if (job_s2.circle) begin
			v1x = rim(job_s2.vx[0], job_s2.neg1[0], pm_s2[0]);
			v1y = rim(job_s2.vy[0], job_s2.neg1[1], pm_s2[1]);
			v2x = rim(job_s2.vx[0], job_s2.neg2[0], pm_s2[2]);
			v2y = rim(job_s2.vy[0], job_s2.neg2[1], pm_s2[3]);
		end else begin
			v1x = job_s2.vx[1];
			v1y = job_s2.vy[1];
			v2x = job_s2.vx[2];
			v2y = job_s2.vy[2];
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			out_q.v0x <= sat32(job_s2.vx[0]);
			out_q.v0y <= sat32(job_s2.vy[0]);
			out_q.v1x <= sat32(v1x);
			out_q.v1y <= sat32(v1y);
			out_q.v2x <= sat32(v2x);
			out_q.v2y <= sat32(v2y);
			out_q.z <= job_s2.z;
			out_q.c0 <= job_s2.col[0];
			out_q.c1 <= job_s2.col[1];
			out_q.c2 <= job_s2.col[2];
			out_q.last <= job_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tri = out_q;

endmodule

// ----- rtl/core/primitive_triangle_tessellator_2d_unit.sv -----
// ----------------------------------------------------------------------------
// primitive_triangle_tessellator_2d_unit
// Turns one quad, circle or thick line into its triangles.
//
//   channel | handshake            | beat
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | one primitive
//   out     | out_valid / out_ready| one triangle, last_triangle on final
//
// A primitive may enter in any cycle in which in_ready is high; the front
// pipeline is 71 stages (square root and divide stages, one bit each) and
// the back end 5 more. Quads and lines leave as 2 triangles, circles as 16,
// set by the triangle sequencer issuing one triangle a cycle unless stalled.
// Reset clears all valid bits and the sequencer; no clearing pass.
// A stalled output holds the whole back end and, once the sequencer is
// full, the front pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module primitive_triangle_tessellator_2d_unit
	import ptt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic [30:0]        radius,
	input  logic [30:0]        thickness_a,
	input  logic [30:0]        thickness_b,
	input  logic [31:0]        color_a,
	input  logic [31:0]        color_b,
	input  logic signed [31:0] depth_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vert0_x,
	output logic signed [31:0] vert0_y,
	output logic signed [31:0] vert1_x,
	output logic signed [31:0] vert1_y,
	output logic signed [31:0] vert2_x,
	output logic signed [31:0] vert2_y,
	output logic signed [31:0] vert_z,
	output logic [31:0]        vert0_color,
	output logic [31:0]        vert1_color,
	output logic [31:0]        vert2_color,
	output logic               last_triangle
);

	item_t item;
	logic  fr_valid;
	prim_t fr_prim;
	stat_t stat;
	logic  fr_en;
	tri_t  tri_o;

	always_comb begin
		item.op = op_t'(operation);
		item.ax = first_x;
		item.ay = first_y;
		item.bx = second_x;
		item.by = second_y;
		item.rad = radius;
		item.ta = thickness_a;
		item.tb = thickness_b;
		item.ca = color_a;
		item.cb = color_b;
		item.z = depth_z;
	end

	assign fr_en = !fr_valid || stat.take;
	assign in_ready = fr_en;

	ptt_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fr_en),
		.in_valid  (in_valid),
		.in_item   (item),
		.res_valid (fr_valid),
		.res       (fr_prim)
	);

	ptt_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_prim   (fr_prim),
		.out_ready (out_ready),
		.stat      (stat),
		.out_valid (out_valid),
		.out_tri   (tri_o)
	);

	assign vert0_x = tri_o.v0x;
	assign vert0_y = tri_o.v0y;
	assign vert1_x = tri_o.v1x;
	assign vert1_y = tri_o.v1y;
	assign vert2_x = tri_o.v2x;
	assign vert2_y = tri_o.v2y;
	assign vert_z = tri_o.z;
	assign vert0_color = tri_o.c0;
	assign vert1_color = tri_o.c1;
	assign vert2_color = tri_o.c2;
	assign last_triangle = tri_o.last;

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !stat.take |=> fr_valid && $stable(fr_prim))
		else $error("front result changed while waiting for the sequencer");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.issue |-> stat.busy)
		else $error("triangle issued with no primitive loaded");

	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		stat.issue && stat.last |=> !stat.busy || $past(fr_valid))
		else $error("sequencer busy after last triangle without a new primitive");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

endmodule
